[hdl/ssb_am_iq_modulator_core_macros.svh]
// ----------------------------------------------------------------------------
// SSB/AM I-Q modulator assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SSB_AM_IQ_MODULATOR_CORE_MACROS_SVH
`define SSB_AM_IQ_MODULATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define SSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SSB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`else
`define SSB_ASSERT(lbl, prop, msg)
`define SSB_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`endif

`endif

[hdl/ssb_pkg.sv]
// ----------------------------------------------------------------------------
// SSB/AM I-Q modulator package
// Widths, register codes, filter coefficient tables and the sequencer
// control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ssb_pkg;

  localparam int unsigned TAPS      = 15;
  localparam int unsigned CENTRE    = 7;
  localparam int unsigned HIL_STEPS = 8;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned COEF_W    = 13;
  localparam int unsigned PROD_W    = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W     = PROD_W + 1;
  localparam int unsigned DAC_W     = 12;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned HSEL_W    = 3;
  localparam int unsigned QV_W      = 14;
  localparam int unsigned SUM_W     = 15;

  localparam logic [MODE_W-1:0] MODE_USB  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LSB  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AM   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ZERO = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_RST = MODE_USB;
  localparam logic [DAC_W-1:0]  BIAS_RST = 12'd2048;
  localparam logic [DAC_W-1:0]  TOP_RST  = 12'd4095;

  localparam logic signed [COEF_W-1:0] LP_COEF [TAPS] = '{
    13'sd3,   13'sd4,   -13'sd3,  -13'sd14, -13'sd15,
    13'sd6,   13'sd38,  13'sd53,  13'sd38,  13'sd6,
    -13'sd15, -13'sd14, -13'sd3,  13'sd4,   13'sd3
  };

  localparam logic [STEP_W-1:0] HIL_TAP [HIL_STEPS] = '{
    4'd0, 4'd14, 4'd2, 4'd12, 4'd4, 4'd10, 4'd6, 4'd8
  };

  localparam logic signed [COEF_W-1:0] HIL_COEF [HIL_STEPS] = '{
    13'sd315,  -13'sd315,  13'sd440,  -13'sd440,
    13'sd734,  -13'sd734,  13'sd2202, -13'sd2202
  };

  typedef struct packed {
    logic              busy;
    logic              accept;
    logic              mac_clr;
    logic              mac_en;
    logic              hil;
    logic [STEP_W-1:0] step;
    logic              shift_filt;
    logic              load_qi;
    logic              load_out;
  } seq_ctl_t;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

endpackage

`default_nettype wire

[hdl/ssb_mac.sv]
// ----------------------------------------------------------------------------
// SSB/AM I-Q modulator shared multiply-accumulate unit
// Registered signed product followed by an accumulator, one term per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_mac (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire ssb_pkg::mac_ctl_t                   ctl_i,
  input  wire logic signed [ssb_pkg::SAMPLE_W-1:0] a_i,
  input  wire logic signed [ssb_pkg::COEF_W-1:0]   b_i,
  output logic signed [ssb_pkg::ACC_W-1:0]         acc_o
);

  logic signed [ssb_pkg::PROD_W-1:0] prod_q;
  logic                              pv_q;
  logic signed [ssb_pkg::ACC_W-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctl_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ssb_pkg::ACC_W'(prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

[hdl/ssb_seq.sv]
// ----------------------------------------------------------------------------
// SSB/AM I-Q modulator sequencer
// Steps the shared MAC through the low-pass taps, then the Hilbert taps,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssb_seq (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               out_free_i,
  output ssb_pkg::seq_ctl_t ctl_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FIR  = 8'b0000_0010,
    S_FDRN = 8'b0000_0100,
    S_FSHF = 8'b0000_1000,
    S_HIL  = 8'b0001_0000,
    S_HDRN = 8'b0010_0000,
    S_QSEL = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  localparam logic [ssb_pkg::STEP_W-1:0] FIR_LAST = ssb_pkg::STEP_W'(ssb_pkg::TAPS - 1);
  localparam logic [ssb_pkg::STEP_W-1:0] HIL_LAST =
    ssb_pkg::STEP_W'(ssb_pkg::HIL_STEPS - 1);

  state_e                        state_q, state_d;
  logic [ssb_pkg::STEP_W-1:0]    step_q, step_d;

  always_comb begin
    state_d          = state_q;
    step_d           = step_q;
    ctl_o            = '0;
    ctl_o.step       = step_q;
    ctl_o.busy       = (state_q != S_IDLE);
    ctl_o.hil        = (state_q == S_HIL);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept  = 1'b1;
          ctl_o.mac_clr = 1'b1;
          step_d        = '0;
          state_d       = S_FIR;
        end
      end
      S_FIR: begin
        ctl_o.mac_en = 1'b1;
        if (step_q == FIR_LAST) begin
          step_d  = '0;
          state_d = S_FDRN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_FDRN: begin
        state_d = S_FSHF;
      end
      S_FSHF: begin
        ctl_o.shift_filt = 1'b1;
        ctl_o.mac_clr    = 1'b1;
        step_d           = '0;
        state_d          = S_HIL;
      end
      S_HIL: begin
        ctl_o.mac_en = 1'b1;
        if (step_q == HIL_LAST) begin
          step_d  = '0;
          state_d = S_HDRN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_HDRN: begin
        state_d = S_QSEL;
      end
      S_QSEL: begin
        ctl_o.load_qi = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          ctl_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

[hdl/ssb_am_iq_modulator_core.sv]
// i_out_o/q_out_o are loaded into the output register after the low-pass and
// Hilbert passes; no new item is accepted until then, and a pending output
// holds the sequencer. The single shared MAC runs 15 low-pass and 8 Hilbert terms.
// Reset: both delay lines clear to zero, mode USB, bias 2048, top 4095,
// no result pending.
// ----------------------------------------------------------------------------
// SSB/AM I-Q modulator core
// Low-pass FIR and 15-tap Hilbert transform on one shared MAC, with mode
// select, bias and clamp to DAC codes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ssb_am_iq_modulator_core_macros.svh"

module ssb_am_iq_modulator_core (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      cfg_we_i,
  input  wire logic [ssb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [ssb_pkg::DAC_W-1:0]           cfg_data_i,
  input  wire                                      in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [ssb_pkg::SAMPLE_W-1:0] audio_sample_i,
  output logic                                     out_valid_o,
  input  wire                                      out_ready_i,
  output logic [ssb_pkg::DAC_W-1:0]                i_out_o,
  output logic [ssb_pkg::DAC_W-1:0]                q_out_o
);

  ssb_pkg::seq_ctl_t                     ctl;
  ssb_pkg::mac_ctl_t                     mac_ctl;
  logic [ssb_pkg::MODE_W-1:0]            mode_q;
  logic [ssb_pkg::DAC_W-1:0]             dac_bias_q;
  logic [ssb_pkg::DAC_W-1:0]             dac_top_q;
  logic signed [ssb_pkg::SAMPLE_W-1:0]   raw_q  [ssb_pkg::TAPS];
  logic signed [ssb_pkg::SAMPLE_W-1:0]   filt_q [ssb_pkg::TAPS];
  logic [ssb_pkg::STEP_W-1:0]            tap;
  logic [ssb_pkg::HSEL_W-1:0]            hsel;
  logic signed [ssb_pkg::SAMPLE_W-1:0]   mac_a;
  logic signed [ssb_pkg::COEF_W-1:0]     mac_b;
  logic signed [ssb_pkg::ACC_W-1:0]      acc;
  logic signed [ssb_pkg::ACC_W-1:0]      fir_biased;
  logic signed [ssb_pkg::ACC_W-1:0]      hil_biased;
  logic signed [ssb_pkg::SAMPLE_W-1:0]   fir_val;
  logic signed [ssb_pkg::COEF_W-1:0]     hil_val;
  logic signed [ssb_pkg::SAMPLE_W-1:0]   centre;
  logic signed [ssb_pkg::QV_W-1:0]       qv;
  logic signed [ssb_pkg::QV_W-1:0]       i8_q, q8_q;
  logic signed [ssb_pkg::SUM_W-1:0]      i_sum, q_sum;
  logic                                  out_free;

  function automatic logic signed [ssb_pkg::QV_W-1:0] div8(
    input logic signed [ssb_pkg::QV_W-1:0] v
  );
    logic signed [ssb_pkg::QV_W-1:0] b;
    b = v + (v[ssb_pkg::QV_W-1] ? ssb_pkg::QV_W'(7) : ssb_pkg::QV_W'(0));
    return b >>> 3;
  endfunction

  function automatic logic [ssb_pkg::DAC_W-1:0] clamp_dac(
    input logic signed [ssb_pkg::SUM_W-1:0] v,
    input logic        [ssb_pkg::DAC_W-1:0] top
  );
    logic signed [ssb_pkg::SUM_W-1:0] t;
    t = $signed(ssb_pkg::SUM_W'(top));
    if (v < 0) begin
      return '0;
    end else if (v > t) begin
      return top;
    end else begin
      return v[ssb_pkg::DAC_W-1:0];
    end
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ssb_pkg::MODE_RST;
      dac_bias_q <= ssb_pkg::BIAS_RST;
      dac_top_q  <= ssb_pkg::TOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssb_pkg::CFG_MODE: mode_q     <= cfg_data_i[ssb_pkg::MODE_W-1:0];
        ssb_pkg::CFG_BIAS: dac_bias_q <= cfg_data_i;
        ssb_pkg::CFG_TOP:  dac_top_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ssb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .ctl_o      (ctl)
  );

  assign in_ready_o = !ctl.busy;
  assign out_free   = !out_valid_o || out_ready_i;

  // Delay lines, oldest entry at index 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ssb_pkg::TAPS; i++) begin
        raw_q[i]  <= '0;
        filt_q[i] <= '0;
      end
    end else begin
      if (ctl.accept) begin
        for (int i = 0; i < ssb_pkg::TAPS - 1; i++) begin
          raw_q[i] <= raw_q[i+1];
        end
        raw_q[ssb_pkg::TAPS-1] <= audio_sample_i;
      end
      if (ctl.shift_filt) begin
        for (int i = 0; i < ssb_pkg::TAPS - 1; i++) begin
          filt_q[i] <= filt_q[i+1];
        end
        filt_q[ssb_pkg::TAPS-1] <= fir_val;
      end
    end
  end

  // Operand select for the shared MAC
  assign hsel  = ctl.step[ssb_pkg::HSEL_W-1:0];
  assign tap   = ctl.hil ? ssb_pkg::HIL_TAP[hsel] : ctl.step;
  assign mac_a = ctl.hil ? filt_q[tap] : raw_q[tap];
  assign mac_b = ctl.hil ? ssb_pkg::HIL_COEF[hsel] : ssb_pkg::LP_COEF[tap];

  assign mac_ctl.clr = ctl.mac_clr;
  assign mac_ctl.en  = ctl.mac_en;

  ssb_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // Truncate toward zero: bias negative sums before the arithmetic shift
  assign fir_biased = acc + (acc[ssb_pkg::ACC_W-1] ? ssb_pkg::ACC_W'(255) : ssb_pkg::ACC_W'(0));
  assign hil_biased = acc + (acc[ssb_pkg::ACC_W-1] ? ssb_pkg::ACC_W'(4095) : ssb_pkg::ACC_W'(0));
  assign fir_val    = fir_biased[8 +: ssb_pkg::SAMPLE_W];
  assign hil_val    = hil_biased[12 +: ssb_pkg::COEF_W];
  assign centre     = filt_q[ssb_pkg::CENTRE];

  always_comb begin
    case (mode_q)
      ssb_pkg::MODE_USB: qv = -ssb_pkg::QV_W'(hil_val);
      ssb_pkg::MODE_LSB: qv = ssb_pkg::QV_W'(hil_val);
      ssb_pkg::MODE_AM:  qv = ssb_pkg::QV_W'(centre);
      default:           qv = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load_qi) begin
      i8_q <= div8(ssb_pkg::QV_W'(centre));
      q8_q <= div8(qv);
    end
  end

  assign i_sum = $signed(ssb_pkg::SUM_W'(dac_bias_q)) + ssb_pkg::SUM_W'(i8_q);
  assign q_sum = $signed(ssb_pkg::SUM_W'(dac_bias_q)) - ssb_pkg::SUM_W'(q8_q);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load_out) begin
      i_out_o <= clamp_dac(i_sum, dac_top_q);
      q_out_o <= clamp_dac(q_sum, dac_top_q);
    end
  end

  `SSB_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "accepted item did not start work")
  `SSB_ASSERT(a_load_needs_slot, ctl.load_out |-> (!out_valid_o || out_ready_i), "result overwrote pending output")
  `SSB_ASSERT(a_idle_mac_quiet, in_ready_o |-> (!ctl.mac_en && !ctl.load_qi), "datapath active while idle")
  `SSB_ASSERT(a_valid_from_load, $rose(out_valid_o) |-> $past(ctl.load_out), "output valid without load")

endmodule

`default_nettype wire

[dv/tb_ssb_am_iq_modulator_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SSB/AM I-Q modulator core testbench
// A directed table of samples and register writes runs first, then about 450
// random samples over ten register settings. Results are checked against an
// in-bench model of the low-pass, Hilbert, mode, bias and clamp chain, or codes
// fixed in the table. Random gaps and stalls are applied on both handshakes.
// ----------------------------------------------------------------------------

module tb_ssb_am_iq_modulator_core;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 45;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [ssb_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int LP_TAPS [15] = '{3, 4, -3, -14, -15, 6, 38, 53, 38, 6, -15, -14, -3, 4, 3};

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct packed {
    logic [ssb_pkg::DAC_W-1:0] i_code;
    logic [ssb_pkg::DAC_W-1:0] q_code;
  } dac_pair_t;

  typedef struct packed {
    row_kind_e                           kind;
    logic [ssb_pkg::CFG_IDX_W-1:0]       idx;
    logic [ssb_pkg::DAC_W-1:0]           data;
    logic signed [ssb_pkg::SAMPLE_W-1:0] sample;
    logic                                typed;
    dac_pair_t                           want;
  } row_t;

  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                cfg_we_i       = 1'b0;
  logic [ssb_pkg::CFG_IDX_W-1:0]       cfg_idx_i      = '0;
  logic [ssb_pkg::DAC_W-1:0]           cfg_data_i     = '0;
  logic                                in_valid_i     = 1'b0;
  logic                                in_ready_o;
  logic signed [ssb_pkg::SAMPLE_W-1:0] audio_sample_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i    = 1'b0;
  logic [ssb_pkg::DAC_W-1:0]           i_out_o;
  logic [ssb_pkg::DAC_W-1:0]           q_out_o;

  int                         raw_hist [15];
  int                         filt_hist [15];
  logic [ssb_pkg::MODE_W-1:0] mode_m;
  int                         bias_m;
  int                         top_m;

  dac_pair_t   dac_expected [$];
  row_t        stim_rows [$];
  dac_pair_t   head;
  int          errors     = 0;
  int          n_items    = 0;
  int          n_results  = 0;
  int          cycles     = 0;
  int          mode_items [4];
  bit          idle_on    = 1'b1;
  int unsigned rdy_hold   = 0;

  ssb_am_iq_modulator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .audio_sample_i (audio_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .i_out_o        (i_out_o),
    .q_out_o        (q_out_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int clamp_code(input int v);
    if (v < 0) return 0;
    if (v > top_m) return top_m;
    return v;
  endfunction

  function automatic dac_pair_t modulate(input logic signed [ssb_pkg::SAMPLE_W-1:0] s);
    int        k;
    int        acc;
    int        hil;
    int        qv;
    int        mid;
    dac_pair_t r;
    acc = 0;
    for (k = 0; k < 14; k++) begin
      raw_hist[k]  = raw_hist[k+1];
      filt_hist[k] = filt_hist[k+1];
    end
    raw_hist[14] = int'(s);
    for (k = 0; k < 15; k++) acc += raw_hist[k] * LP_TAPS[k];
    filt_hist[14] = acc / 256;
    mid = filt_hist[7];
    hil = ((filt_hist[0] - filt_hist[14]) * 315 + (filt_hist[2] - filt_hist[12]) * 440 +
           (filt_hist[4] - filt_hist[10]) * 734 + (filt_hist[6] - filt_hist[8]) * 2202) / 4096;
    case (mode_m)
      ssb_pkg::MODE_USB: qv = -hil;
      ssb_pkg::MODE_LSB: qv = hil;
      ssb_pkg::MODE_AM:  qv = mid;
      default:           qv = 0;
    endcase
    r.i_code = ssb_pkg::DAC_W'(clamp_code(bias_m + mid / 8));
    r.q_code = ssb_pkg::DAC_W'(clamp_code(bias_m - qv / 8));
    return r;
  endfunction

  function automatic void item_row(input logic signed [ssb_pkg::SAMPLE_W-1:0] s,
                                   input logic typed,
                                   input logic [ssb_pkg::DAC_W-1:0] i_code,
                                   input logic [ssb_pkg::DAC_W-1:0] q_code);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.sample = s;
    r.typed = typed;
    r.want.i_code = i_code;
    r.want.q_code = q_code;
    stim_rows.push_back(r);
  endfunction

  function automatic void write_row(input logic [ssb_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [ssb_pkg::DAC_W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    stim_rows.push_back(r);
  endfunction

  task automatic set_reg(input logic [ssb_pkg::CFG_IDX_W-1:0] idx,
                         input logic [ssb_pkg::DAC_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      ssb_pkg::CFG_MODE: mode_m = data[ssb_pkg::MODE_W-1:0];
      ssb_pkg::CFG_BIAS: bias_m = int'(data);
      ssb_pkg::CFG_TOP:  top_m  = int'(data);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (dac_expected.size() != 0);
  endtask

  task automatic send_sample(input logic signed [ssb_pkg::SAMPLE_W-1:0] s, input logic typed,
                             input dac_pair_t want);
    int unsigned gap;
    dac_pair_t   p;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    audio_sample_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    p = modulate(s);
    dac_expected.push_back(typed ? want : p);
    mode_items[mode_m]++;
    n_items++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      rdy_hold <= idle_on ? $urandom_range(0, 3) : 0;
      if (dac_expected.size() == 0) begin
        errors++;
        $error("unexpected result: i_out %0d q_out %0d", i_out_o, q_out_o);
      end else begin
        head = dac_expected.pop_front();
        if (i_out_o !== head.i_code) begin
          errors++;
          $error("i_out: expected %0d, got %0d", head.i_code, i_out_o);
        end
        if (q_out_o !== head.q_code) begin
          errors++;
          $error("q_out: expected %0d, got %0d", head.q_code, q_out_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rdy_hold != 0) begin
        out_ready_i <= 1'b0;
        rdy_hold    <= rdy_hold - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int                                  k;
    int                                  ph;
    int                                  it;
    int unsigned                         pick;
    logic [ssb_pkg::MODE_W-1:0]          mode_pick;
    logic [ssb_pkg::DAC_W-1:0]           bias_pick;
    logic [ssb_pkg::DAC_W-1:0]           top_pick;
    logic signed [ssb_pkg::SAMPLE_W-1:0] s;
    logic signed [ssb_pkg::SAMPLE_W-1:0] walk;
    row_t                                row;
    for (k = 0; k < 15; k++) begin
      raw_hist[k]  = 0;
      filt_hist[k] = 0;
    end
    for (k = 0; k < 4; k++) mode_items[k] = 0;
    mode_m = ssb_pkg::MODE_USB;
    bias_m = 2048;
    top_m  = 4095;
    walk   = '0;

    item_row(12'sd0, 1'b1, 12'd2048, 12'd2048);
    item_row(12'sd2047, 1'b0, '0, '0);
    item_row(-12'sd2048, 1'b0, '0, '0);
    for (k = 0; k < 15; k++) item_row(LP_TAPS[k] >= 0 ? 12'sd2047 : -12'sd2048, 1'b0, '0, '0);
    write_row(ssb_pkg::CFG_MODE, 12'hFFD);
    item_row(-12'sd1000, 1'b0, '0, '0);
    write_row(ssb_pkg::CFG_MODE, {10'd0, ssb_pkg::MODE_AM});
    item_row(12'sd1500, 1'b0, '0, '0);
    write_row(ssb_pkg::CFG_MODE, {10'd0, ssb_pkg::MODE_ZERO});
    write_row(ssb_pkg::CFG_TOP, 12'd100);
    write_row(ssb_pkg::CFG_BIAS, 12'd4095);
    item_row(12'sd2047, 1'b1, 12'd100, 12'd100);
    write_row(ssb_pkg::CFG_TOP, 12'd0);
    item_row(-12'sd2048, 1'b1, 12'd0, 12'd0);
    write_row(CFG_UNUSED, 12'h7FF);
    item_row(12'sd5, 1'b1, 12'd0, 12'd0);
    write_row(ssb_pkg::CFG_BIAS, 12'd0);
    write_row(ssb_pkg::CFG_TOP, 12'd4095);
    item_row(12'sd0, 1'b0, '0, '0);
    write_row(ssb_pkg::CFG_MODE, {10'd0, ssb_pkg::MODE_USB});
    write_row(ssb_pkg::CFG_BIAS, 12'd2048);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[n]) begin
      row = stim_rows[n];
      if (row.kind == ROW_WRITE) begin
        settle();
        set_reg(row.idx, row.data);
      end else begin
        send_sample(row.sample, row.typed, row.want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      idle_on = (ph % 4) != 3;
      mode_pick = (ph < 4) ? ssb_pkg::MODE_W'(ph) : ssb_pkg::MODE_W'($urandom_range(0, 3));
      set_reg(ssb_pkg::CFG_MODE, {10'($urandom), mode_pick});
      pick = $urandom_range(0, 5);
      case (pick)
        0:       bias_pick = 12'd0;
        1:       bias_pick = 12'd4095;
        2:       bias_pick = 12'd2048;
        default: bias_pick = ssb_pkg::DAC_W'($urandom);
      endcase
      set_reg(ssb_pkg::CFG_BIAS, bias_pick);
      pick = $urandom_range(0, 7);
      case (pick)
        0:       top_pick = 12'd0;
        1:       top_pick = ssb_pkg::DAC_W'($urandom_range(2048, 4095));
        2:       top_pick = ssb_pkg::DAC_W'($urandom);
        default: top_pick = 12'd4095;
      endcase
      set_reg(ssb_pkg::CFG_TOP, top_pick);
      if ($urandom_range(0, 3) == 0) set_reg(CFG_UNUSED, ssb_pkg::DAC_W'($urandom));
      for (it = 0; it < PHASE_ITEMS; it++) begin
        pick = $urandom_range(0, 9);
        case (pick)
          6:       s = $urandom_range(0, 1) ? 12'sd2047 : -12'sd2048;
          7:       s = ssb_pkg::SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
          8, 9: begin
            walk = walk + ssb_pkg::SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
            s = walk;
          end
          default: s = ssb_pkg::SAMPLE_W'($urandom);
        endcase
        send_sample(s, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Summary: %0d samples sent, %0d results compared, %0d mismatches",
             n_items, n_results, errors);
    $display("Samples per mode: USB %0d, LSB %0d, AM %0d, Q zero %0d",
             mode_items[0], mode_items[1], mode_items[2], mode_items[3]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/ssb_pkg.sv
hdl/ssb_mac.sv
hdl/ssb_seq.sv
hdl/ssb_am_iq_modulator_core.sv
dv/tb_ssb_am_iq_modulator_core.sv
